@@ sv/tfra_pkg.sv @@
`default_nettype none
package tfra_pkg;

  localparam int SLOT_DEPTH_DEF      = 64;
  localparam int ARENA_MAX_BYTES_DEF = 16777216;

  // opcodes
  localparam logic [2:0] OP_PUSH  = 3'd0;
  localparam logic [2:0] OP_GET   = 3'd1;
  localparam logic [2:0] OP_SEEK  = 3'd2;
  localparam logic [2:0] OP_PIN   = 3'd3;
  localparam logic [2:0] OP_UNPIN = 3'd4;
  localparam logic [2:0] OP_CLEAR = 3'd5;
  localparam logic [2:0] OP_STATS = 3'd6;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ARG      = 3'd1;
  localparam logic [2:0] ST_BIG      = 3'd2;
  localparam logic [2:0] ST_ORDER    = 3'd3;
  localparam logic [2:0] ST_PINFULL  = 3'd4;
  localparam logic [2:0] ST_NOTFOUND = 3'd5;

  // register indexes
  localparam logic [1:0] CFG_WINDOW = 2'd0;
  localparam logic [1:0] CFG_ARENA  = 2'd1;
  localparam logic [1:0] CFG_SLOTS  = 2'd2;

  localparam logic [9:0] MS_PER_SEC = 10'd1000;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [24:0] frame_length;
    logic [47:0] time_ms;
    logic [31:0] sequence_number;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] result_sequence;
    logic [23:0] frame_offset;
    logic [24:0] result_length;
    logic [47:0] result_time_ms;
    logic [6:0]  frames_held;
    logic [24:0] bytes_in_use;
    logic        pin_active;
    logic [31:0] age_evictions;
    logic [31:0] space_evictions;
    logic [31:0] slot_evictions;
    logic [31:0] pinned_rejects;
  } out_t;

  // one descriptor
  typedef struct packed {
    logic [23:0] offset;
    logic [24:0] length;
    logic [47:0] time_ms;
  } ent_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_AGE_RD, S_AGE_EV, S_SLOT_RD, S_SLOT_EV,
    S_SPC_RD, S_SPC_EV, S_COMMIT, S_GET_RD, S_GET_EV, S_SRCH,
    S_SRCH_EV, S_STAT_RD, S_STAT_EV, S_DONE
  } state_t;

endpackage
`default_nettype wire

@@ sv/tfra_slot_mem.sv @@
`default_nettype none
module tfra_slot_mem import tfra_pkg::*; #(
  parameter int DEPTH = SLOT_DEPTH_DEF,
  parameter int AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire ent_t          wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output ent_t               rd_data
);

  ent_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, holds between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ sv/timed_frame_ring_allocator_top.sv @@
`default_nettype none
// Timed frame ring allocator: descriptor manager for a circular byte arena
// of timestamped frames (push, get, seek, pin, unpin, clear, stats).
// Input channel in_valid/in_stall/in_data: one command per transfer, taken
// only while the sequencer is idle. Result channel out_valid/out_stall/
// out_data: one result per command, held in an output register, so the
// next command is taken while a result still waits for the receiver.
// Push, get, seek, pin and stats read descriptors through the single memory
// read port; seek and pin binary-search by time, and push first evicts
// frames by age, slot count and space, wrapping the head if needed.
// If the receiver stalls, the finished result waits in the sequencer's
// done state until the output register frees up.
// Config port: cfg_we/cfg_index/cfg_wdata; the user must write it only
// while idle, the block does not enforce this. A nonzero write to
// arena_bytes or slots_in_use reinitializes the ring, sequences, pin and
// counters. Zero writes are ignored.
// Reset (rst_n low, synchronous): empty ring, window 10 s, full arena and
// slot count, no result pending. Descriptor memory is not cleared.
module timed_frame_ring_allocator_top import tfra_pkg::*; #(
  parameter int SLOT_DEPTH      = SLOT_DEPTH_DEF,
  parameter int ARENA_MAX_BYTES = ARENA_MAX_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_t             out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [24:0] cfg_wdata
);

  localparam int AW = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
  localparam int ARENA_RESET = (ARENA_MAX_BYTES < 16777216) ? ARENA_MAX_BYTES : 16777216;
  localparam int SLOTS_RESET = (SLOT_DEPTH < 64) ? SLOT_DEPTH : 64;

  // configuration
  logic [25:0] window_ms_r;
  logic [24:0] arena_r;
  logic [6:0]  slots_r;

  // ring state
  state_t      state_r, state_nxt;
  in_t         in_r;
  logic [24:0] wh_r;
  logic [6:0]  oldest_r;
  logic [6:0]  count_r;
  logic [31:0] oldest_seq_r;
  logic [31:0] next_seq_r;
  logic [24:0] bytes_r;
  logic        pin_r;
  logic [31:0] pin_seq_r;
  logic [31:0] age_cnt_r, space_cnt_r, slot_cnt_r, rej_cnt_r;
  logic [47:0] newest_r;

  // per-command work registers
  logic [6:0]  lo_r, hi_r, mid_r;
  logic [2:0]  res_status_r;
  logic [31:0] res_seq_r;
  logic [23:0] res_off_r;
  logic [24:0] res_len_r;
  logic [47:0] res_time_r;

  logic        out_valid_r;
  out_t        out_data_r;

  // memory side
  logic        mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  ent_t        mem_wdata, rd;

  // shared slot index unit: (oldest + pos) mod slots
  logic [6:0]  pos_sel;
  logic [7:0]  slot_sum;
  logic [6:0]  slot_idx;

  logic [31:0] get_d;
  logic        get_miss;
  logic [6:0]  mid;
  logic [31:0] pin_diff;
  logic        pin_old;
  logic        age_hit;
  logic [24:0] rd_off;
  logic        spc_fit, spc_wrap;
  logic        drop;
  logic [6:0]  oldest_inc;
  logic        cfg_reinit;
  logic [24:0] cfg_arena_v;
  logic [6:0]  cfg_slots_v;
  logic        out_free;

  assign get_d    = in_r.sequence_number - oldest_seq_r;
  assign get_miss = (count_r == 7'd0) || (get_d >= {25'd0, count_r});
  assign mid      = lo_r + ((hi_r - lo_r) >> 1);
  assign pin_diff = oldest_seq_r - pin_seq_r;
  assign pin_old  = pin_r && !pin_diff[31];
  assign age_hit  = (in_r.time_ms - rd.time_ms) > {22'd0, window_ms_r};
  assign rd_off   = {1'b0, rd.offset};
  assign spc_fit  = (rd_off >= wh_r) ? ((rd_off - wh_r) >= in_r.frame_length)
                                     : ((arena_r - wh_r) >= in_r.frame_length);
  assign spc_wrap = (rd_off < wh_r) && !spc_fit;
  assign oldest_inc = (oldest_r + 7'd1 == slots_r) ? 7'd0 : oldest_r + 7'd1;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    unique case (state_r)
      S_GET_RD: pos_sel = get_d[6:0];
      S_SRCH:   pos_sel = mid;
      S_COMMIT: pos_sel = count_r;
      default:  pos_sel = 7'd0;
    endcase
    slot_sum = {1'b0, oldest_r} + {1'b0, pos_sel};
    slot_idx = (slot_sum >= {1'b0, slots_r}) ? 7'(slot_sum - {1'b0, slots_r})
                                             : slot_sum[6:0];
  end

  // eviction of the oldest frame this cycle
  always_comb begin
    unique case (state_r)
      S_AGE_EV:  drop = age_hit && !pin_old;
      S_SLOT_EV: drop = !pin_old;
      S_SPC_EV:  drop = !spc_fit && !spc_wrap && !pin_old;
      default:   drop = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_data.opcode)
            OP_PUSH:          state_nxt = S_CHECK;
            OP_GET:           state_nxt = S_GET_RD;
            OP_SEEK, OP_PIN:  state_nxt = S_SRCH;
            OP_STATS:         state_nxt = S_STAT_RD;
            default:          state_nxt = S_DONE;
          endcase
        end
      end
      S_CHECK: begin
        if (in_r.frame_length == 25'd0 || in_r.frame_length > arena_r ||
            (count_r != 7'd0 && in_r.time_ms < newest_r)) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_AGE_RD;
        end
      end
      S_AGE_RD:  state_nxt = (count_r == 7'd0) ? S_SLOT_RD : S_AGE_EV;
      S_AGE_EV:  state_nxt = drop ? S_AGE_RD : S_SLOT_RD;
      S_SLOT_RD: state_nxt = (count_r >= slots_r) ? S_SLOT_EV : S_SPC_RD;
      S_SLOT_EV: state_nxt = drop ? S_SLOT_RD : S_DONE;
      S_SPC_RD:  state_nxt = (count_r == 7'd0) ? S_COMMIT : S_SPC_EV;
      S_SPC_EV: begin
        priority if (spc_fit) begin
          state_nxt = S_COMMIT;
        end else if (spc_wrap) begin
          state_nxt = S_SPC_EV;
        end else if (drop) begin
          state_nxt = S_SPC_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_COMMIT:  state_nxt = S_DONE;
      S_GET_RD:  state_nxt = get_miss ? S_DONE : S_GET_EV;
      S_GET_EV:  state_nxt = S_DONE;
      S_SRCH:    state_nxt = (lo_r < hi_r) ? S_SRCH_EV : S_DONE;
      S_SRCH_EV: state_nxt = S_SRCH;
      S_STAT_RD: state_nxt = (count_r > 7'd1) ? S_STAT_EV : S_DONE;
      S_STAT_EV: state_nxt = S_DONE;
      S_DONE:    state_nxt = out_free ? S_IDLE : S_DONE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // memory control outputs
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = AW'(oldest_r);
    mem_we    = 1'b0;
    mem_waddr = AW'(slot_idx);
    mem_wdata = '{offset: wh_r[23:0], length: in_r.frame_length, time_ms: in_r.time_ms};
    unique case (state_r)
      S_AGE_RD, S_SLOT_RD, S_SPC_RD, S_STAT_RD: mem_re = 1'b1;
      S_GET_RD: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(slot_idx);
      end
      S_SRCH: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(slot_idx);
      end
      S_COMMIT: mem_we = 1'b1;
      default: ;
    endcase
  end

  tfra_slot_mem #(
    .DEPTH (SLOT_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (rd)
  );

  assign cfg_arena_v = ({7'd0, cfg_wdata} > 32'(ARENA_MAX_BYTES)) ? 25'(ARENA_MAX_BYTES)
                                                                   : cfg_wdata;
  assign cfg_slots_v = ({25'd0, cfg_wdata[6:0]} > 32'(SLOT_DEPTH)) ? 7'(SLOT_DEPTH)
                                                                    : cfg_wdata[6:0];
  assign cfg_reinit  = cfg_we && ((cfg_index == CFG_ARENA && cfg_wdata != 25'd0) ||
                                  (cfg_index == CFG_SLOTS && cfg_wdata[6:0] != 7'd0));

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_ms_r <= 26'd10000;
      arena_r     <= 25'(ARENA_RESET);
      slots_r     <= 7'(SLOTS_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW: if (cfg_wdata[15:0] != 16'd0)
          window_ms_r <= 26'(cfg_wdata[15:0]) * 26'(MS_PER_SEC);
        CFG_ARENA:  if (cfg_wdata != 25'd0) arena_r <= cfg_arena_v;
        CFG_SLOTS:  if (cfg_wdata[6:0] != 7'd0) slots_r <= cfg_slots_v;
        default: ;
      endcase
    end
  end

  // ring control state
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_reinit) begin
      state_r      <= S_IDLE;
      wh_r         <= '0;
      oldest_r     <= '0;
      count_r      <= '0;
      oldest_seq_r <= '0;
      next_seq_r   <= '0;
      bytes_r      <= '0;
      pin_r        <= 1'b0;
      pin_seq_r    <= '0;
      age_cnt_r    <= '0;
      space_cnt_r  <= '0;
      slot_cnt_r   <= '0;
      rej_cnt_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (drop) begin
        bytes_r      <= bytes_r - rd.length;
        oldest_r     <= oldest_inc;
        oldest_seq_r <= oldest_seq_r + 32'd1;
        count_r      <= count_r - 7'd1;
        if (count_r == 7'd1) wh_r <= '0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (in_data.opcode == OP_UNPIN) pin_r <= 1'b0;
            if (in_data.opcode == OP_CLEAR) begin
              wh_r         <= '0;
              oldest_r     <= '0;
              count_r      <= '0;
              bytes_r      <= '0;
              oldest_seq_r <= next_seq_r;
              pin_r        <= 1'b0;
            end
          end
        end
        S_AGE_EV: if (drop) age_cnt_r <= age_cnt_r + 32'd1;
        S_SLOT_EV: begin
          if (drop) slot_cnt_r <= slot_cnt_r + 32'd1;
          else rej_cnt_r <= rej_cnt_r + 32'd1;
        end
        S_SPC_RD: if (count_r == 7'd0) wh_r <= '0;
        S_SPC_EV: begin
          if (spc_wrap) wh_r <= '0;
          else if (drop) space_cnt_r <= space_cnt_r + 32'd1;
          else if (!spc_fit) rej_cnt_r <= rej_cnt_r + 32'd1;
        end
        S_COMMIT: begin
          if (count_r == 7'd0) oldest_seq_r <= next_seq_r;
          wh_r       <= wh_r + in_r.frame_length;
          bytes_r    <= bytes_r + in_r.frame_length;
          count_r    <= count_r + 7'd1;
          next_seq_r <= next_seq_r + 32'd1;
        end
        S_SRCH: begin
          if (!(lo_r < hi_r) && in_r.opcode == OP_PIN) begin
            pin_r     <= 1'b1;
            pin_seq_r <= (lo_r < count_r) ? oldest_seq_r + {25'd0, lo_r} : next_seq_r;
          end
        end
        default: ;
      endcase
    end
  end

  // per-command payload registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        in_r         <= in_data;
        lo_r         <= '0;
        hi_r         <= count_r;
        res_status_r <= (in_data.opcode > OP_STATS) ? ST_ARG : ST_OK;
        res_seq_r    <= '0;
        res_off_r    <= '0;
        res_len_r    <= '0;
        res_time_r   <= '0;
      end
      S_CHECK: begin
        priority if (in_r.frame_length == 25'd0) begin
          res_status_r <= ST_ARG;
        end else if (in_r.frame_length > arena_r) begin
          res_status_r <= ST_BIG;
        end else if (count_r != 7'd0 && in_r.time_ms < newest_r) begin
          res_status_r <= ST_ORDER;
        end else begin
          res_status_r <= ST_OK;
        end
      end
      S_SLOT_EV: if (!drop) res_status_r <= ST_PINFULL;
      S_SPC_EV: if (!spc_fit && !spc_wrap && !drop) res_status_r <= ST_PINFULL;
      S_COMMIT: begin
        res_seq_r <= next_seq_r;
        res_off_r <= wh_r[23:0];
        newest_r  <= in_r.time_ms;
      end
      S_GET_RD: if (get_miss) res_status_r <= ST_NOTFOUND;
      S_GET_EV: begin
        res_off_r  <= rd.offset;
        res_len_r  <= rd.length;
        res_time_r <= rd.time_ms;
      end
      S_SRCH: begin
        if (lo_r < hi_r) begin
          mid_r <= mid;
        end else if (in_r.opcode == OP_PIN) begin
          res_seq_r <= (lo_r < count_r) ? oldest_seq_r + {25'd0, lo_r} : next_seq_r;
        end else if (lo_r < count_r) begin
          res_seq_r <= oldest_seq_r + {25'd0, lo_r};
        end else begin
          res_status_r <= ST_NOTFOUND;
        end
      end
      S_SRCH_EV: begin
        if (rd.time_ms < in_r.time_ms) lo_r <= mid_r + 7'd1;
        else hi_r <= mid_r;
      end
      S_STAT_EV: res_time_r <= newest_r - rd.time_ms;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_data_r <= '{status:          res_status_r,
                      result_sequence: res_seq_r,
                      frame_offset:    res_off_r,
                      result_length:   res_len_r,
                      result_time_ms:  res_time_r,
                      frames_held:     count_r,
                      bytes_in_use:    bytes_r,
                      pin_active:      pin_r,
                      age_evictions:   age_cnt_r,
                      space_evictions: space_cnt_r,
                      slot_evictions:  slot_cnt_r,
                      pinned_rejects:  rej_cnt_r};
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= slots_r) else $error("frame count above slot count");

  a_empty_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == 7'd0 |-> bytes_r == 25'd0) else $error("bytes held with no frames");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !cfg_reinit |=> state_r != S_IDLE)
    else $error("accepted transfer left sequencer idle");

  a_bytes_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_r <= arena_r) else $error("bytes in use above arena size");

endmodule
`default_nettype wire
